@@ sv/keyed_fifo_remove_by_key_unit_defines.svh @@
// Assertion macros used by the keyed FIFO sequencer (kfrk_ctrl).
// Users must have signals named clock and reset in scope.
`ifndef KEYED_FIFO_REMOVE_BY_KEY_UNIT_DEFINES_SVH
`define KEYED_FIFO_REMOVE_BY_KEY_UNIT_DEFINES_SVH

// Plain clocked check, off while reset is high.
`define KFRK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that also skips the first edge after reset, for $past-based terms.
`define KFRK_ASSERT_SETTLED(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (!$past(reset) && (ante)) |-> (cons)) else $error(msg);

`endif

@@ sv/kfrk_pkg.sv @@
// Package for the keyed FIFO remove-by-key unit: sizes, status codes,
// sequencer states and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kfrk_pkg;

   localparam int unsigned DEPTH  = 16;
   localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned KEY_W  = 32;
   localparam int unsigned CAP_W  = 5;
   localparam int unsigned STAT_W = 3;
   localparam int unsigned POS_W  = 4;
   localparam int unsigned OCC_W  = 5;
   localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic REQ_ENTER = 1'b0;
   localparam logic REQ_EXIT  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_APPENDED  = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
   localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND  = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_FINISH
   } kfrk_state_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  cars_ahead;
      logic [POS_W-1:0]  cars_behind;
      logic [OCC_W-1:0]  occupancy;
   } kfrk_result_type;

endpackage

`default_nettype wire

@@ sv/kfrk_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kfrk_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/kfrk_ctrl.sv @@
// Sequencer for the keyed FIFO: walks the key RAM to search, compacts on
// removal, appends, and holds the result register. Uses kfrk_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_fifo_remove_by_key_unit_defines.svh"

module kfrk_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_type,
   input  wire logic [kfrk_pkg::KEY_W-1:0] req_plate,
   input  wire logic [kfrk_pkg::CAP_W-1:0] cap,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output kfrk_pkg::kfrk_result_type       rsp,
   output logic                            ram_wr_en,
   output logic [kfrk_pkg::IDX_W-1:0]      ram_wr_addr,
   output logic [kfrk_pkg::KEY_W-1:0]      ram_wr_data,
   output logic                            ram_rd_en,
   output logic [kfrk_pkg::IDX_W-1:0]      ram_rd_addr,
   input  wire logic [kfrk_pkg::KEY_W-1:0] ram_rd_data
);
   import kfrk_pkg::*;

   kfrk_state_type  state_ff, state_in;
   logic            op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic            rvalid_ff, rvalid_in;
   logic [IDX_W-1:0] chk_ff, chk_in;
   kfrk_result_type res_ff, res_in;
   logic            out_valid_ff, out_valid_in;
   kfrk_result_type out_ff, out_in;

   logic accept;
   logic match;
   logic more;
   logic out_free;
   logic at_cap;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign match     = rvalid_ff && (ram_rd_data == key_ff);
   assign more      = (issue_ff < cnt_ff);
   assign out_free  = !out_valid_ff || rsp_ready;
   // capacity above the built depth saturates at the depth
   assign at_cap    = (CMP_W'(cnt_ff) >= CMP_W'(cap)) || (cnt_ff == CNT_W'(DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (match) begin
               state_in = (op_ff == REQ_EXIT) ? ST_SHIFT : ST_FINISH;
            end else if (!rvalid_ff && !more) begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            if (!rvalid_ff) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      rvalid_in    = 1'b0;
      chk_in       = chk_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_in       = out_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = chk_ff - IDX_W'(1);
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_type;
               key_in   = req_plate;
               issue_in = '0;
            end
         end
         ST_SEARCH: begin
            ram_rd_en = more;
            rvalid_in = more;
            if (more) begin
               issue_in = issue_ff + CNT_W'(1);
               chk_in   = issue_ff[IDX_W-1:0];
            end
            if (match) begin
               if (op_ff == REQ_EXIT) begin
                  res_in.status      = STAT_REMOVED;
                  res_in.cars_ahead  = POS_W'(chk_ff);
                  res_in.cars_behind = POS_W'(cnt_ff - CNT_W'(1) - CNT_W'(chk_ff));
                  res_in.occupancy   = OCC_W'(cnt_ff - CNT_W'(1));
               end else begin
                  res_in.status      = STAT_DUPLICATE;
                  res_in.cars_ahead  = '0;
                  res_in.cars_behind = '0;
                  res_in.occupancy   = OCC_W'(cnt_ff);
               end
            end else if (!rvalid_ff && !more) begin
               res_in.cars_ahead  = '0;
               res_in.cars_behind = '0;
               res_in.occupancy   = OCC_W'(cnt_ff);
               if (op_ff == REQ_EXIT) begin
                  res_in.status = STAT_NOTFOUND;
               end else if (at_cap) begin
                  res_in.status = STAT_FULL;
               end else begin
                  ram_wr_en        = 1'b1;
                  ram_wr_addr      = cnt_ff[IDX_W-1:0];
                  ram_wr_data      = key_ff;
                  cnt_in           = cnt_ff + CNT_W'(1);
                  res_in.status    = STAT_APPENDED;
                  res_in.occupancy = OCC_W'(cnt_ff + CNT_W'(1));
               end
            end
         end
         ST_SHIFT: begin
            // reads run two slots ahead of writes: no same-entry overlap
            ram_rd_en = more;
            rvalid_in = more;
            if (more) begin
               issue_in = issue_ff + CNT_W'(1);
               chk_in   = issue_ff[IDX_W-1:0];
            end
            if (rvalid_ff) begin
               ram_wr_en = 1'b1;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rvalid_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rvalid_ff    <= rvalid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      issue_ff <= issue_in;
      chk_ff   <= chk_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   `KFRK_ASSERT(a_shift_wr_below_tail, (state_ff == ST_SHIFT && ram_wr_en) |-> (CNT_W'(ram_wr_addr) < (cnt_ff - CNT_W'(1))), "compaction write past tail")
   `KFRK_ASSERT_SETTLED(a_cnt_moves_at_end, (cnt_ff != $past(cnt_ff)), (state_ff == ST_FINISH), "entry count changed mid-walk")
   `KFRK_ASSERT(a_append_within_cap, (state_ff == ST_FINISH && res_ff.status == STAT_APPENDED) |-> (CMP_W'(res_ff.occupancy) <= CMP_W'(cap)), "append beyond capacity")
   `KFRK_ASSERT(a_remove_counts, (state_ff == ST_FINISH && res_ff.status == STAT_REMOVED) |-> ((OCC_W'(res_ff.cars_ahead) + OCC_W'(res_ff.cars_behind)) == res_ff.occupancy), "ahead/behind do not add up")

endmodule

`default_nettype wire

@@ sv/keyed_fifo_remove_by_key_unit.sv @@
// Top level of the keyed FIFO with remove-by-key: capacity register, key RAM,
// sequencer. Uses kfrk_pkg, kfrk_ram, kfrk_ctrl.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   req     | req_valid / req_ready | req_type, req_plate
//   rsp     | rsp_valid / rsp_ready | rsp_status, rsp_cars_ahead,
//           |                       | rsp_cars_behind, rsp_occupancy
//   csr     | csr_wr_en (no wait)   | csr_wr_data (capacity)
//
// One transaction at a time. The time from accept to result register grows
// with N, the stored count, and is set by the single read port of the key
// RAM walked one slot per cycle; a duplicate enter stops at its match.
// Reset is synchronous and active high; it empties the queue and sets
// capacity to 16. RAM contents are not cleared (slots past the count are
// never read). A stalled rsp holds the result; the next request can be taken
// while it waits, and finishes once the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module keyed_fifo_remove_by_key_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_type,
   input  wire logic [kfrk_pkg::KEY_W-1:0]  req_plate,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [kfrk_pkg::STAT_W-1:0]      rsp_status,
   output logic [kfrk_pkg::POS_W-1:0]       rsp_cars_ahead,
   output logic [kfrk_pkg::POS_W-1:0]       rsp_cars_behind,
   output logic [kfrk_pkg::OCC_W-1:0]       rsp_occupancy,
   input  wire logic                        csr_wr_en,
   input  wire logic [kfrk_pkg::CAP_W-1:0]  csr_wr_data
);
   import kfrk_pkg::*;

   // capacity register; the user must write it only while idle, the block itself does not enforce this
   logic [CAP_W-1:0] cap_ff;

   kfrk_result_type  rsp;

   // key RAM ports
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [KEY_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [KEY_W-1:0] ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // slot 0 holds the oldest key; the queue is kept packed from slot 0
   kfrk_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // search walk, compaction on removal, append, result register
   kfrk_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_plate   (req_plate),
      .cap         (cap_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   assign rsp_status      = rsp.status;
   assign rsp_cars_ahead  = rsp.cars_ahead;
   assign rsp_cars_behind = rsp.cars_behind;
   assign rsp_occupancy   = rsp.occupancy;

endmodule

`default_nettype wire

@@ tb/keyed_fifo_remove_by_key_unit_tb.sv @@
// Self-checking testbench for keyed_fifo_remove_by_key_unit: directed and random
// enter/exit traffic, with random stalls on both channels and capacity changes.
// Depends on kfrk_pkg and the unit RTL.
`timescale 1ns / 1ps

module keyed_fifo_remove_by_key_unit_tb;
   import kfrk_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_type = REQ_ENTER;
   logic [KEY_W-1:0]    req_plate = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [POS_W-1:0]    rsp_cars_ahead;
   logic [POS_W-1:0]    rsp_cars_behind;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                csr_wr_en = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data = '0;

   // Shadow of the lot: slot 0 is the oldest plate. Capacity as last written.
   logic [KEY_W-1:0]    lot_plates[$];
   logic [CAP_W-1:0]    lot_capacity = CAP_RESET;

   // Predicted responses, oldest first; pushed when a request transaction is taken.
   kfrk_result_type     pending_responses[$];

   int unsigned         error_count = 0;
   bit                  back_to_back = 1'b0;   // both sides run with no idle cycles
   int unsigned         hold_off_cycles = 0;   // one-shot long stall of the receiver
   int unsigned         fresh_plate = 0;

   keyed_fifo_remove_by_key_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_plate       (req_plate),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_cars_ahead  (rsp_cars_ahead),
      .rsp_cars_behind (rsp_cars_behind),
      .rsp_occupancy   (rsp_occupancy),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Applies one request to the shadow lot and returns the response it causes.
   // Duplicate check comes before the capacity check, so a duplicate while
   // full still reports duplicate. Usable capacity saturates at DEPTH.
   function automatic kfrk_result_type predict_lot_response(logic kind,
                                                            logic [KEY_W-1:0] plate);
      kfrk_result_type res;
      int slot;
      int usable;
      slot = -1;
      foreach (lot_plates[i])
         if (slot < 0 && lot_plates[i] == plate) slot = i;
      usable = (lot_capacity > DEPTH) ? DEPTH : int'(lot_capacity);
      res = '0;
      if (kind == REQ_ENTER) begin
         if (slot >= 0) begin
            res.status = STAT_DUPLICATE;
         end else if (lot_plates.size() >= usable) begin
            res.status = STAT_FULL;
         end else begin
            lot_plates.push_back(plate);
            res.status = STAT_APPENDED;
         end
      end else if (slot >= 0) begin
         res.cars_ahead  = POS_W'(slot);
         res.cars_behind = POS_W'(lot_plates.size() - 1 - slot);
         lot_plates.delete(slot);
         res.status = STAT_REMOVED;
      end else begin
         res.status = STAT_NOTFOUND;
      end
      res.occupancy = OCC_W'(lot_plates.size());
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic int unsigned draw_wait();
      return back_to_back ? 0 : $urandom_range(0, 11);
   endfunction

   // Half the time a plate already parked (so exits hit and enters collide),
   // otherwise a small recurring pool near both ends of the range, or noise.
   function automatic logic [KEY_W-1:0] pick_plate();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5 && lot_plates.size() > 0)
         return lot_plates[$urandom_range(0, lot_plates.size() - 1)];
      if (roll < 8)
         return ($urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}})
                ^ KEY_W'($urandom_range(0, 23));
      return $urandom();
   endfunction

   function automatic logic [KEY_W-1:0] new_plate();
      fresh_plate++;
      return 32'hC0DE_0000 + fresh_plate;
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Entered at a falling edge; returns at the falling edge after acceptance
   // with req_valid still high, so a following transaction can go back to back.
   task automatic send_request(input logic kind, input logic [KEY_W-1:0] plate);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_plate <= plate;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_responses.push_back(predict_lot_response(kind, plate));
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (pending_responses.size() != 0) @(negedge clock);
   endtask

   // Every request yields exactly one response, so an empty prediction queue
   // means the unit is idle and the register can be rewritten.
   task automatic settle_and_set_capacity(input logic [CAP_W-1:0] value);
      req_valid <= 1'b0;
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      lot_capacity  = value;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset capacity of 16: empty exit, extreme plates, duplicate, miss,
   // filling to full, duplicate while full, removes at middle / head / tail.
   task automatic test_enter_exit_basics();
      send_request(REQ_EXIT, 32'h0000_0000);
      send_request(REQ_ENTER, 32'h0000_0000);
      send_request(REQ_ENTER, 32'hFFFF_FFFF);
      send_request(REQ_ENTER, 32'h0000_0000);
      send_request(REQ_EXIT, 32'h1234_5678);
      for (int i = 0; i < 14; i++) send_request(REQ_ENTER, 32'h5A5A_0000 + i);
      send_request(REQ_ENTER, 32'hA5A5_A5A5);
      send_request(REQ_ENTER, 32'hFFFF_FFFF);
      send_request(REQ_EXIT, lot_plates[7]);
      send_request(REQ_EXIT, lot_plates[0]);
      send_request(REQ_EXIT, lot_plates[lot_plates.size() - 1]);
   endtask

   // Capacity zero, above DEPTH, lowered under the stored count, and one.
   task automatic test_capacity_limits();
      settle_and_set_capacity(5'd0);
      send_request(REQ_ENTER, new_plate());
      send_request(REQ_ENTER, lot_plates[0]);
      send_request(REQ_EXIT, lot_plates[0]);

      settle_and_set_capacity(5'd31);
      while (lot_plates.size() < DEPTH) send_request(REQ_ENTER, new_plate());
      send_request(REQ_ENTER, new_plate());

      // 16 stored against 15 slots: enters bounce until the count drops below.
      settle_and_set_capacity(5'd15);
      send_request(REQ_ENTER, new_plate());
      send_request(REQ_EXIT, lot_plates[lot_plates.size() - 1]);
      send_request(REQ_ENTER, new_plate());
      send_request(REQ_EXIT, lot_plates[3]);
      send_request(REQ_ENTER, new_plate());

      settle_and_set_capacity(5'd1);
      send_request(REQ_ENTER, new_plate());
      settle_and_set_capacity(CAP_RESET);
   endtask

   // Receiver stalls long enough that the unit backs up into req_ready,
   // then the sender pauses for a full drain before a back-to-back burst.
   task automatic test_back_pressure();
      hold_off_cycles = 150;
      for (int i = 0; i < 10; i++)
         send_request($urandom_range(0, 1) ? REQ_EXIT : REQ_ENTER, pick_plate());
      req_valid <= 1'b0;
      wait_for_drain();
      back_to_back = 1'b1;
      for (int i = 0; i < 8; i++)
         send_request($urandom_range(0, 1) ? REQ_EXIT : REQ_ENTER, pick_plate());
      back_to_back = 1'b0;
   endtask

   // Phases at different capacities; within a phase the mix swings between
   // filling and emptying so occupancy sweeps the whole range.
   task automatic test_random_traffic();
      logic [CAP_W-1:0] phase_caps[6];
      int unsigned fill_pct;
      logic kind;
      phase_caps = '{5'd16, 5'd6, 5'd31, 5'd1, 5'd0, 5'd11};
      for (int p = 0; p < 6; p++) begin
         settle_and_set_capacity(phase_caps[p]);
         back_to_back = (p == 2);
         for (int n = 0; n < 275; n++) begin
            fill_pct = ((n / 40) % 2 == 0) ? 75 : 30;
            kind = ($urandom_range(0, 99) < fill_pct) ? REQ_ENTER : REQ_EXIT;
            send_request(kind, pick_plate());
         end
      end
      back_to_back = 1'b0;
      settle_and_set_capacity(CAP_RESET);
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Draws a stall per response; a pending long hold is served first.
   initial begin : response_receiver
      int unsigned stall;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         stall = draw_wait();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !reset));
      end
   end

   // Compares each response transaction with the oldest prediction.
   always @(posedge clock) begin : response_checker
      kfrk_result_type got;
      kfrk_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.status      = rsp_status;
         got.cars_ahead  = rsp_cars_ahead;
         got.cars_behind = rsp_cars_behind;
         got.occupancy   = rsp_occupancy;
         if (pending_responses.size() == 0) begin
            note_failure($sformatf("unexpected response %p", got));
         end else begin
            want = pending_responses.pop_front();
            if (got.status !== want.status || got.cars_ahead !== want.cars_ahead ||
                got.cars_behind !== want.cars_behind || got.occupancy !== want.occupancy)
               note_failure($sformatf("response mismatch: expected %p, actual %p",
                                      want, got));
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_enter_exit_basics();
      test_capacity_limits();
      test_back_pressure();
      test_random_traffic();

      // The last request walks at most DEPTH stored keys; allow a margin.
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (40) @(negedge clock);
      if (pending_responses.size() != 0)
         note_failure($sformatf("%0d responses never arrived", pending_responses.size()));
      if (error_count == 0)
         $display("keyed_fifo_remove_by_key_unit verification clean");
      else
         $display("keyed_fifo_remove_by_key_unit verification failed");
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("keyed_fifo_remove_by_key_unit verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/kfrk_pkg.sv
sv/kfrk_ram.sv
sv/kfrk_ctrl.sv
sv/keyed_fifo_remove_by_key_unit.sv
tb/keyed_fifo_remove_by_key_unit_tb.sv
